// ----- sv/cimg_pkg.sv -----
// Shared types, byte constants and a case-folding helper for the case-insensitive glob matcher.
// No dependencies; imported by cimg_cell, cimg_loader and the top level.
`default_nettype none

package cimg_pkg;

  // Pattern and text byte codes
  localparam logic [7:0] STAR     = 8'h2a;  // '*'
  localparam logic [7:0] QMARK    = 8'h3f;  // '?'
  localparam logic [7:0] UPPER_A  = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_Z  = 8'h5a;  // 'Z'
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4
  } cfg_reg_t;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic       step;     // input beat accepted this cycle
    logic       present;  // beat carries a real byte
    logic       last;     // beat ends the string
    logic [7:0] fc;       // case-folded text byte
  } step_t;

  // Signals a cell hands to its right neighbor
  typedef struct packed {
    logic act;   // stored active bit
    logic star;  // cell is a live '*'
    logic adv;   // token moves one position right on this byte
    logic nxt;   // next-state bit before star closure
  } link_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/case_insensitive_glob_matcher.sv -----
// Top level of the case-insensitive glob matcher: loader, chain of position cells,
// output register. Depends on cimg_pkg, cimg_loader and cimg_cell.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in_     | input     | in_valid/in_ready   | in_text_byte, in_byte_present, in_final_byte
//  out_    | output    | out_valid/out_ready | out_string_done, out_is_match, out_still_possible
//  cfg_    | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One beat per cycle while in_ready is high; the whole cell row and the output register
// both update in the cycle a beat is accepted.
// Each configuration write starts a normalization sweep over min(length, MAX_PATTERN)
// raw pattern bytes, one raw pattern byte per cycle, during which in_ready is low.
// After reset the pattern is empty, the sweep is idle and position zero is active.
// A stalled result holds in the output register; a new beat is taken in the cycle it leaves.
`default_nettype none

module case_insensitive_glob_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_byte_present,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_string_done,
  output logic        out_is_match,
  output logic        out_still_possible,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cimg_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN + 1);
  localparam int N  = MAX_PATTERN + 1;

  logic          busy;
  logic [IW-1:0] cnt;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_byte;
  step_t         ctl;
  link_t         lnk [N+1];
  logic [N-1:0]  fin_vec;
  logic [N-1:0]  act_vec;
  logic          step;

  logic out_valid_r;
  logic out_string_done_r;
  logic out_is_match_r;
  logic out_still_possible_r;

  cimg_loader #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_loader (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (busy),
    .cnt      (cnt),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_byte  (wr_byte)
  );

  // Handshake and broadcast control
  always_comb begin
    in_ready = !busy && (!out_valid_r || out_ready);
    step     = in_valid && in_ready;
    ctl      = '{step: step, present: in_byte_present, last: in_final_byte,
                 fc: fold_case(in_text_byte)};
  end

  assign lnk[0] = '0;

  // Cell row: one cell per position, the last one is the end-of-pattern position
  for (genvar k = 0; k < N; k++) begin : g_cell
    cimg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .valid    (IW'(k) < cnt),
      .home     (k == 0),
      .pat_we   (wr_en && (wr_addr == IW'(k))),
      .pat_wbyte(wr_byte),
      .left     (lnk[k]),
      .right    (lnk[k+1]),
      .fin      (fin_vec[k])
    );
    assign act_vec[k] = lnk[k+1].act;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_string_done_r    <= in_final_byte;
      out_is_match_r       <= in_final_byte && fin_vec[cnt];
      out_still_possible_r <= |fin_vec;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_string_done    = out_string_done_r;
  assign out_is_match       = out_is_match_r;
  assign out_still_possible = out_still_possible_r;

  // Checks
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("beat could be accepted right after a configuration write");

  a_match_implies: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_match) |-> (out_string_done && out_still_possible))
    else $error("match reported without end of string or live position");

  a_home_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_final_byte) |=> (act_vec == N'(1)))
    else $error("active positions not returned home after end of string");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= IW'(MAX_PATTERN))
    else $error("normalized pattern length exceeds capacity");

endmodule

`default_nettype wire

// ----- sv/cimg_cell.sv -----
// One pattern position of the matcher chain: holds a pattern byte and one active bit.
// Depends on cimg_pkg (step_t, link_t, byte constants).
`default_nettype none

module cimg_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  cimg_pkg::step_t ctl,
  input  logic            valid,      // position lies inside the normalized pattern
  input  logic            home,       // active bit value after reset / end of string
  input  logic            pat_we,
  input  logic [7:0]      pat_wbyte,
  input  cimg_pkg::link_t left,
  output cimg_pkg::link_t right,
  output logic            fin         // active bit after this beat, before any end-of-string return home
);
  import cimg_pkg::*;

  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;
  logic       star;
  logic       act_c;
  logic       hit;
  logic       adv;
  logic       nxt;
  logic       nc;

  // Pattern byte, loaded by the normalization sweep
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_wbyte;
    end
  end

  // Position logic. Normalized patterns never hold two stars in a row,
  // so one closure step from the left neighbor is enough.
  always_comb begin
    star    = valid && (pat_r == STAR);
    act_c   = act_r | (left.act & left.star);
    hit     = (pat_r == QMARK) || (pat_r == ctl.fc);
    adv     = act_c & valid & ~star & hit;
    nxt     = (act_c & star) | left.adv;
    nc      = nxt | (left.nxt & left.star);
    fin     = ctl.present ? nc : act_c;
    act_nxt = ctl.last ? home : fin;
    right   = '{act: act_r, star: star, adv: adv, nxt: nxt};
  end

  // Active bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= home;
    end else if (ctl.step) begin
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cimg_loader.sv -----
// Configuration registers and the pattern normalization sweep that loads the cells.
// Depends on cimg_pkg (cfg_reg_t, fold_case, byte constants).
`default_nettype none

module cimg_loader #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [63:0]                          cfg_data,
  output logic                                 busy,
  output logic [$clog2(MAX_PATTERN+1)-1:0]     cnt,
  output logic                                 wr_en,
  output logic [$clog2(MAX_PATTERN+1)-1:0]     wr_addr,
  output logic [7:0]                           wr_byte
);
  import cimg_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN + 1);

  logic [63:0]   pat_r [4];
  logic [5:0]    len_r;
  logic          busy_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] cnt_r;
  logic          tail_star_r;

  logic [IW-1:0] eff_len;
  logic [255:0]  pat_flat;
  logic [5:0]    idx_ext;
  logic [7:0]    bit_sel;
  logic [7:0]    fb;
  logic          drop;
  logic          at_end;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0] <= '0;
      pat_r[1] <= '0;
      pat_r[2] <= '0;
      pat_r[3] <= '0;
      len_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT0: pat_r[0] <= cfg_data;
        REG_PAT1: pat_r[1] <= cfg_data;
        REG_PAT2: pat_r[2] <= cfg_data;
        REG_PAT3: pat_r[3] <= cfg_data;
        REG_LEN:  len_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Current raw byte, folded; wildcards right after a kept star are dropped
  always_comb begin
    eff_len  = (len_r > 6'(MAX_PATTERN)) ? IW'(MAX_PATTERN) : IW'(len_r);
    pat_flat = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};
    idx_ext  = 6'(idx_r);
    bit_sel  = {idx_ext[4:0], 3'b000};
    fb       = fold_case(pat_flat[bit_sel +: 8]);
    drop     = tail_star_r && (fb == STAR || fb == QMARK);
    at_end   = (idx_r == eff_len);
    wr_en    = busy_r && !at_end && !drop;
    wr_addr  = cnt_r;
    wr_byte  = fb;
    busy     = busy_r;
    cnt      = cnt_r;
  end

  // Sweep: one raw byte per cycle, restarted by every register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      tail_star_r <= 1'b0;
    end else if (cfg_we) begin
      busy_r      <= 1'b1;
      idx_r       <= '0;
      cnt_r       <= '0;
      tail_star_r <= 1'b0;
    end else if (busy_r) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
        if (!drop) begin
          cnt_r       <= cnt_r + IW'(1);
          tail_star_r <= (fb == STAR);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/case_insensitive_glob_matcher_test.sv -----
// Self-checking bench for the case-insensitive glob matcher: streams strings against
// programmed patterns and checks every result beat. Depends on cimg_pkg and the RTL.

module case_insensitive_glob_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cimg_pkg::*;

  // One result beat as seen on the out_ channel
  typedef struct packed {
    logic done;
    logic hit;
    logic alive;
  } verdict_t;

  // Tracks the pattern registers and active positions, and queues the verdicts they imply
  class glob_verdicts;
    logic [63:0] pat_word [4];
    logic [5:0]  pat_len;
    logic [32:0] live;
    logic [7:0]  norm [32];
    int          norm_len;
    verdict_t    pending [$];
    int          errors;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      pat_len  = '0;
      live     = 33'd1;
      norm_len = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[idx[1:0]] = data;
        REG_LEN: pat_len = data[5:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      if (c >= UPPER_A && c <= UPPER_Z) return c + 8'd32;
      return c;
    endfunction

    // Clamp the length, fold case, drop any '*' or '?' right after a '*'
    function void rebuild_pattern();
      int lim;
      logic [7:0] b;
      lim = (pat_len > 6'd32) ? 32 : int'(pat_len);
      norm_len = 0;
      for (int i = 0; i < lim; i++) begin
        b = to_lower(pat_word[i / 8][(i % 8) * 8 +: 8]);
        if (norm_len > 0 && norm[norm_len - 1] == STAR && (b == STAR || b == QMARK)) continue;
        norm[norm_len] = b;
        norm_len++;
      end
    endfunction

    function logic [32:0] close_stars(logic [32:0] v);
      for (int i = 0; i < norm_len; i++) begin
        if (v[i] && norm[i] == STAR) v[i + 1] = 1'b1;
      end
      return v;
    endfunction

    // Advance the position vector by one accepted input beat
    function void note_beat(logic [7:0] c, logic present, logic last);
      logic [32:0] act;
      logic [32:0] nxt;
      logic [7:0]  fc;
      verdict_t    v;
      rebuild_pattern();
      act = close_stars(live);
      if (present) begin
        fc  = to_lower(c);
        nxt = '0;
        for (int i = 0; i < norm_len; i++) begin
          if (!act[i]) continue;
          if (norm[i] == STAR) nxt[i] = 1'b1;
          else if (norm[i] == QMARK || norm[i] == fc) nxt[i + 1] = 1'b1;
        end
        act = close_stars(nxt);
      end
      v.done  = last;
      v.hit   = last && act[norm_len];
      v.alive = |act;
      pending.insert(pending.size(), v);
      live = last ? 33'd1 : act;
    endfunction

    function void compare_field(string field, logic want, logic got, realtime at);
      if (got !== want) begin
        $display("%0.1f ns: %s mismatch, expected %0b, actual %0b", at, field, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got, realtime at);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0.1f ns: unexpected result beat, expected none, actual %b", at, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("string_done", want.done, got.done, at);
      compare_field("is_match", want.hit, got.hit, at);
      compare_field("still_possible", want.alive, got.alive, at);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 105;
  localparam logic [2:0] SPARE_INDEX = 3'd7;  // not a register; writes are ignored
  localparam logic [7:0] LOWER_A = UPPER_A | CASE_BIT;

  typedef struct {
    logic [7:0] text;
    logic       present;
    logic       last;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_string_done;
  logic        out_is_match;
  logic        out_still_possible;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  glob_verdicts verdicts;
  text_beat_t   str_q [$];
  logic [7:0]   pat_raw [32];
  logic [5:0]   pat_len_raw;
  bit           calm = 1'b1;
  bit           valid_up = 1'b0;
  int           cycles = 0;

  case_insensitive_glob_matcher dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_byte_present(in_byte_present),
    .in_final_byte(in_final_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_string_done(out_string_done),
    .out_is_match(out_is_match),
    .out_still_possible(out_still_possible),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic text_beat_t beat(logic [7:0] c, logic present, logic last);
    text_beat_t b;
    b.text    = c;
    b.present = present;
    b.last    = last;
    return b;
  endfunction

  // Append one beat to the string under construction
  function automatic void enqueue(text_beat_t b);
    str_q.insert(str_q.size(), b);
  endfunction

  // Result side: check accepted beats, stall at random
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        verdicts.check_verdict(verdict_t'({out_string_done, out_is_match, out_still_possible}),
                               $realtime);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Send one input beat, optionally after an idle gap
  task automatic send_beat(input text_beat_t b);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      if (valid_up) in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b.text;
    in_byte_present <= b.present;
    in_final_byte   <= b.last;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    verdicts.note_beat(b.text, b.present, b.last);
  endtask

  task automatic send_text(input string s, input logic close);
    if (s.len() == 0) begin
      send_beat(beat(8'h00, 1'b0, close));
    end else begin
      for (int i = 0; i < s.len(); i++) send_beat(beat(s[i], 1'b1, close && i == s.len() - 1));
    end
  endtask

  // Stop sending and wait until every queued verdict has come back
  task automatic drain();
    if (valid_up) in_valid <= 1'b0;
    valid_up = 1'b0;
    @(posedge clk);
    while (verdicts.pending.size() > 0) @(posedge clk);
  endtask

  // Register write with nothing in flight, then wait out the normalization sweep
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    verdicts.set_reg(idx, data);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [5:0] len);
    logic [63:0] w [4];
    for (int i = 0; i < 32; i++) w[i / 8][(i % 8) * 8 +: 8] = pat_raw[i];
    pat_len_raw = len;
    cfg_write(REG_PAT0, w[0]);
    cfg_write(REG_PAT1, w[1]);
    cfg_write(REG_PAT2, w[2]);
    cfg_write(REG_PAT3, w[3]);
    cfg_write(REG_LEN, {32'($urandom), 26'($urandom), len});
  endtask

  task automatic set_text_pattern(input string s);
    for (int i = 0; i < 32; i++) pat_raw[i] = (i < s.len()) ? s[i] : 8'($urandom);
    load_pattern(6'(s.len()));
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return LOWER_A + 8'($urandom_range(0, 4));
    if (r < 50) return UPPER_A + 8'($urandom_range(0, 4));
    if (r < 65) return STAR;
    if (r < 78) return QMARK;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 1) == 0) return LOWER_A + 8'($urandom_range(0, 4));
    return 8'($urandom);
  endfunction

  // Build one string: mostly shaped by the pattern, some noise and broken ones
  task automatic make_string();
    int lim;
    int k;
    logic [7:0] b;
    str_q.delete();
    lim = (pat_len_raw > 6'd32) ? 32 : int'(pat_len_raw);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 8)) enqueue(beat(pick_text_byte(), 1'b1, 1'b0));
    end else begin
      for (int i = 0; i < lim; i++) begin
        b = pat_raw[i];
        if (b == STAR) begin
          repeat ($urandom_range(0, 3)) enqueue(beat(pick_text_byte(), 1'b1, 1'b0));
        end else if (b == QMARK) begin
          enqueue(beat(8'($urandom), 1'b1, 1'b0));
        end else begin
          // flip the case of letters half the time
          if (((b | CASE_BIT) >= LOWER_A) && ((b | CASE_BIT) <= (UPPER_Z | CASE_BIT))
              && $urandom_range(0, 1) == 1) begin
            b = b ^ CASE_BIT;
          end
          enqueue(beat(b, 1'b1, 1'b0));
        end
      end
      if (str_q.size() > 0 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, str_q.size() - 1);
        case ($urandom_range(0, 2))
          0: str_q[k].text = 8'($urandom);
          1: str_q.delete(k);
          default: str_q.insert(k, beat(8'($urandom), 1'b1, 1'b0));
        endcase
      end
    end
    // beats without a byte sprinkled in
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 2)) begin
        str_q.insert($urandom_range(0, str_q.size()), beat(8'($urandom), 1'b0, 1'b0));
      end
    end
    if (str_q.size() == 0 || $urandom_range(0, 3) == 0) begin
      enqueue(beat(8'($urandom), 1'b0, 1'b1));
    end else begin
      str_q[str_q.size() - 1].last = 1'b1;
    end
  endtask

  initial begin : stimulus
    int sent;
    int lenv;
    verdicts = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a write to a spare index changes nothing
    cfg_write(SPARE_INDEX, {32'($urandom), 32'($urandom)});

    // Empty pattern: only the empty string matches
    send_beat(beat(8'h00, 1'b0, 1'b1));
    send_text("x", 1'b1);

    // Star runs collapse; letters compare without case
    set_text_pattern("a**?b");
    send_text("AxyB", 1'b1);
    send_beat(beat(8'h61, 1'b1, 1'b0));
    send_beat(beat(8'hff, 1'b0, 1'b0));
    send_beat(beat(8'h42, 1'b1, 1'b1));
    send_text("a", 1'b1);
    calm = 1'b0;
    send_text("zb", 1'b1);

    // Pattern change in the middle of a string keeps the active positions
    send_text("a", 1'b0);
    drain();
    set_text_pattern("A?");
    send_text("Q", 1'b1);

    // Characters next to the letter range are not folded
    set_text_pattern("@[");
    send_beat(beat(8'h60, 1'b1, 1'b0));
    send_beat(beat(8'h7b, 1'b1, 1'b1));
    send_text("@[", 1'b1);

    // Length field past the maximum, zero and 0xff bytes, last pattern byte in use
    drain();
    pat_raw[0] = 8'h00;
    pat_raw[1] = STAR;
    for (int i = 2; i < 31; i++) pat_raw[i] = (i % 2 == 1) ? QMARK : STAR;
    pat_raw[31] = 8'hff;
    load_pattern(6'd63);
    send_beat(beat(8'h00, 1'b1, 1'b0));
    send_beat(beat(8'h5a, 1'b1, 1'b0));
    send_beat(beat(8'hff, 1'b1, 1'b1));
    send_beat(beat(8'h00, 1'b1, 1'b0));
    send_beat(beat(8'hff, 1'b1, 1'b0));
    send_beat(beat(8'h00, 1'b0, 1'b1));

    // Random phases, each with a fresh pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      calm = (p % 4 == 3);
      if (p == 0) lenv = 0;
      else if (p == 1) lenv = 32;
      else if (p == 2) lenv = 63;
      else if ($urandom_range(0, 9) < 7) lenv = $urandom_range(1, 10);
      else if ($urandom_range(0, 2) < 2) lenv = $urandom_range(11, 32);
      else lenv = $urandom_range(33, 63);
      for (int i = 0; i < 32; i++) pat_raw[i] = pick_pattern_byte();
      load_pattern(6'(lenv));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_string();
        foreach (str_q[i]) send_beat(str_q[i]);
        sent += str_q.size();
        // hold off once until the result side has caught up
        if (p == 5 && sent >= PHASE_ITEMS / 2 && sent - str_q.size() < PHASE_ITEMS / 2) begin
          drain();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (verdicts.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cimg_pkg.sv
sv/cimg_cell.sv
sv/cimg_loader.sv
sv/case_insensitive_glob_matcher.sv
bench/case_insensitive_glob_matcher_test.sv
